FILE: rtl/core/alec_pkg.sv
// shared types, widths and codes for the loop envelope controller
package alec_pkg;

   localparam int TIME_W         = 24;
   localparam int VOL_W          = 16;
   localparam int LS_W           = 25;
   localparam int RC_W           = 16;
   localparam int CSR_IDX_W      = 8;
   localparam int DIVIDEND_W     = 40;
   localparam int DIVISOR_W      = 24;
   localparam int MAX_POINTS_DEF = 16;

   localparam logic [VOL_W-1:0] VOL_UNITY = VOL_W'(16384);

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_END     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_LIMIT = CSR_IDX_W'(3);

   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_APPEND = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREV,
      S_CUR,
      S_MUL,
      S_PREP,
      S_DIV,
      S_SUM,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] play_offset;
      logic              source_active;
      logic [TIME_W-1:0] point_time;
      logic [VOL_W-1:0]  point_volume;
   } req_type_t_type;

   typedef struct packed {
      logic              seek_valid;
      logic [TIME_W-1:0] seek_pos;
      logic              stop_sound;
      logic              volume_valid;
      logic [VOL_W-1:0]  volume;
      logic              rejected;
   } rsp_type;

endpackage

FILE: rtl/core/alec_div.sv
// serial restoring divider, one quotient bit per cycle
module alec_div import alec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CW = $clog2(DIVIDEND_W);
   localparam logic [CW-1:0] LAST = CW'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit of the difference drops
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/audio_loop_envelope_controller_core.sv
// loop, repeat and piecewise-linear volume envelope controller, top level
//
// req channel: one item is either an envelope point to append or a tick with
// elapsed time, play offset and source-active flag. rsp channel: exactly one
// result item per request item, in order. csr channel: register writes
// (enabled, loop_start, loop_end, repeat_limit), always ready; the user must
// make them while idle, the block itself does not enforce it. One item is in
// work at a time; req_ready is high only when the block is idle. An append or
// a tick that produces no volume goes straight to the final state, which loads
// its result into the output register. A tick that produces a volume reads the
// previous and the current envelope point from the point memory one after the
// other, multiplies once and then runs the 40-step serial divider; when both
// point times match the divider is skipped. Results sit in an output register;
// a stalled receiver holds the block in its final state, and a new item
// is taken as soon as that result is loaded. Reset clears counters, the halt
// flag, the state and the configuration (loop_start to all ones); point entries
// are only read below the fill count, so the memory needs no clearing pass.
module audio_loop_envelope_controller_core import alec_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type_t_type       req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LS_W-1:0]      csr_data
);

   localparam int PW = $clog2(MAX_POINTS + 1);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int EW = TIME_W + VOL_W;

   // configuration
   logic                    enabled_ff;
   logic [LS_W-1:0]         loop_start_ff;
   logic [TIME_W-1:0]       loop_end_ff;
   logic [RC_W-1:0]         repeat_limit_ff;

   // control state
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]       acc_ff, acc_in;
   logic [TIME_W-1:0]       prev_off_ff, prev_off_in;
   logic [RC_W-1:0]         rc_ff, rc_in;
   logic [PW-1:0]           cur_ff, cur_in;
   logic [PW-1:0]           count_ff, count_in;
   logic                    halted_ff, halted_in;

   // payload
   rsp_type                 rsp_data_ff, rsp_data_in;
   rsp_type                 res_ff, res_in;
   logic [TIME_W-1:0]       pt_ff, pt_in;
   logic [VOL_W-1:0]        pv_ff, pv_in;
   logic [VOL_W-1:0]        nv_ff, nv_in;
   logic signed [VOL_W:0]   dv_ff, dv_in;
   logic signed [TIME_W:0]  dt_ff, dt_in;
   logic signed [TIME_W:0]  den_ff, den_in;
   logic                    eq_ff, eq_in;
   logic                    adv_ff, adv_in;
   logic signed [41:0]      prod_ff, prod_in;
   logic                    neg_ff, neg_in;

   // point memory
   logic [EW-1:0]           env_mem [MAX_POINTS];
   logic [EW-1:0]           rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;

   // divider
   logic                    div_start;
   logic                    div_done;
   logic [DIVIDEND_W-1:0]   div_quo;
   logic [41:0]             prod_abs;
   logic [TIME_W:0]         den_abs;

   // tick evaluation
   logic                    accept;
   logic                    live;
   logic                    ls_neg;
   logic [TIME_W-1:0]       ls_pos;
   logic [TIME_W:0]         acc_sum;
   logic [TIME_W-1:0]       acc_new;
   logic                    wrap;
   logic                    pull;
   logic [TIME_W-1:0]       off2;
   logic                    rc_inc;
   logic [RC_W-1:0]         rc_next;
   logic                    has_vol;
   logic                    full;
   logic [PW-1:0]           cur_prev;
   logic [TIME_W-1:0]       rd_time;
   logic [VOL_W-1:0]        rd_vol;
   logic [TIME_W-1:0]       t_clamp;
   logic signed [41:0]      q_s;
   logic signed [41:0]      r_s;
   logic [VOL_W-1:0]        r_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign live    = enabled_ff && !halted_ff;
   assign ls_neg  = loop_start_ff[LS_W-1];
   assign ls_pos  = loop_start_ff[TIME_W-1:0];
   assign acc_sum = {1'b0, acc_ff} + {1'b0, req_data.elapsed};
   assign acc_new = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
   assign wrap    = (loop_end_ff != '0) && (req_data.play_offset >= loop_end_ff);
   assign off2    = wrap ? (ls_neg ? '0 : ls_pos) : req_data.play_offset;
   assign pull    = !ls_neg && (off2 < ls_pos);
   assign rc_inc  = (off2 < prev_off_ff) && (rc_ff != '1);
   assign rc_next = rc_ff + RC_W'(rc_inc);
   assign has_vol = cur_ff < count_ff;
   assign full    = count_ff >= PW'(MAX_POINTS);

   assign cur_prev = cur_ff - PW'(1);
   assign rd_addr  = (state_ff == S_IDLE) ? cur_prev[AW-1:0] : cur_ff[AW-1:0];
   assign wr_en    = accept && (req_data.req_type == REQ_APPEND) && !full;
   assign wr_addr  = count_ff[AW-1:0];
   assign rd_time  = rd_data_ff[EW-1:VOL_W];
   assign rd_vol   = rd_data_ff[VOL_W-1:0];
   assign t_clamp  = (acc_ff < rd_time) ? acc_ff : rd_time;

   assign prod_abs  = prod_ff[41] ? 42'(-prod_ff) : prod_ff;
   assign den_abs   = den_ff[TIME_W] ? (TIME_W+1)'(-den_ff) : den_ff;
   assign div_start = state_ff == S_PREP;

   // signed truncating quotient, then the base volume and a clamp to range
   assign q_s   = neg_ff ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
   assign r_s   = q_s + $signed({26'd0, pv_ff});
   assign r_sat = r_s[41] ? '0 : ((|r_s[40:VOL_W]) ? '1 : r_s[VOL_W-1:0]);

   alec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[DIVIDEND_W-1:0]),
      .divisor  (den_abs[DIVISOR_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         env_mem[wr_addr] <= {req_data.point_time, req_data.point_volume};
      end
      rd_data_ff <= env_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      acc_in       = acc_ff;
      prev_off_in  = prev_off_ff;
      rc_in        = rc_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      halted_in    = halted_ff;
      res_in       = res_ff;
      pt_in        = pt_ff;
      pv_in        = pv_ff;
      nv_in        = nv_ff;
      dv_in        = dv_ff;
      dt_in        = dt_ff;
      den_in       = den_ff;
      eq_in        = eq_ff;
      adv_in       = adv_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = S_FINISH;
               if (req_data.req_type == REQ_APPEND) begin
                  if (full) begin
                     res_in.rejected = 1'b1;
                  end else begin
                     count_in = count_ff + PW'(1);
                  end
               end else if (live) begin
                  acc_in = acc_new;
                  if (req_data.source_active) begin
                     res_in.seek_valid = wrap || pull;
                     res_in.seek_pos   = ((wrap || pull) && !ls_neg) ? ls_pos : '0;
                     prev_off_in       = off2;
                     if (repeat_limit_ff != '0) begin
                        rc_in = rc_next;
                        if (rc_next >= repeat_limit_ff) begin
                           res_in.stop_sound = 1'b1;
                           halted_in         = 1'b1;
                        end
                     end
                     if (has_vol) begin
                        state_in = S_PREV;
                     end
                  end
               end
            end
         end
         S_PREV: begin
            // implied first point at time zero, unity volume
            pt_in    = (cur_ff == '0) ? '0 : rd_time;
            pv_in    = (cur_ff == '0) ? VOL_UNITY : rd_vol;
            state_in = S_CUR;
         end
         S_CUR: begin
            nv_in    = rd_vol;
            dv_in    = $signed({1'b0, rd_vol}) - $signed({1'b0, pv_ff});
            dt_in    = $signed({1'b0, t_clamp}) - $signed({1'b0, pt_ff});
            den_in   = $signed({1'b0, rd_time}) - $signed({1'b0, pt_ff});
            eq_in    = pt_ff == rd_time;
            adv_in   = acc_ff >= rd_time;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = dv_ff * dt_ff;
            neg_in   = (dv_ff[VOL_W] ^ dt_ff[TIME_W]) ^ den_ff[TIME_W];
            state_in = eq_ff ? S_SUM : S_PREP;
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            res_in.volume_valid = 1'b1;
            res_in.volume       = eq_ff ? nv_ff : r_sat;
            if (adv_ff) begin
               cur_in = cur_ff + PW'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         acc_ff          <= '0;
         prev_off_ff     <= '0;
         rc_ff           <= '0;
         cur_ff          <= '0;
         count_ff        <= '0;
         halted_ff       <= 1'b0;
         enabled_ff      <= 1'b0;
         loop_start_ff   <= '1;
         loop_end_ff     <= '0;
         repeat_limit_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         prev_off_ff  <= prev_off_in;
         rc_ff        <= rc_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLED:      enabled_ff      <= csr_data[0];
               CSR_LOOP_START:   loop_start_ff   <= csr_data;
               CSR_LOOP_END:     loop_end_ff     <= csr_data[TIME_W-1:0];
               CSR_REPEAT_LIMIT: repeat_limit_ff <= csr_data[RC_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      pt_ff       <= pt_in;
      pv_ff       <= pv_in;
      nv_ff       <= nv_in;
      dv_ff       <= dv_in;
      dt_ff       <= dt_in;
      den_ff      <= den_in;
      eq_ff       <= eq_in;
      adv_ff      <= adv_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PW'(MAX_POINTS))
      else $error("point count beyond table depth");

   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= count_ff)
      else $error("current point beyond stored points");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result loaded outside the finish state");

endmodule
